/* src/glyph_locator_defines.svh */
// Assertion macros shared by the glyph locator RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef GLYPH_LOCATOR_DEFINES_SVH
`define GLYPH_LOCATOR_DEFINES_SVH

// same-cycle implication
`define GL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/gl_pkg.sv */
// Shared types, codes and constants of the glyph locator.
// No dependencies.
package gl_pkg;

    localparam int TABLE_DEPTH = 8192;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int TBL_CW      = $clog2(TABLE_DEPTH + 1);

    localparam int KIND_W   = 2;
    localparam int POS_W    = 13;
    localparam int KEY_W    = 32;
    localparam int KLEN_W   = 3;
    localparam int GLYPH_W  = 13;
    localparam int SIZE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 32;
    localparam int OFS_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_SIZES = 5;

    localparam logic [KIND_W-1:0] KIND_GBK_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UTF_LOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GBK_FIND = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UTF_FIND = 2'd3;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_NOT_READY = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STS_BAD_SIZE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LIB_READY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_BASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_12   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_16   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_20   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_24   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_32   = 3'd6;

    // result selection codes
    localparam logic [1:0] RES_LOADED    = 2'd0;
    localparam logic [1:0] RES_NOT_READY = 2'd1;
    localparam logic [1:0] RES_NOT_FOUND = 2'd2;
    localparam logic [1:0] RES_HIT       = 2'd3;

    localparam logic [15:0] GBK_END = 16'hFFFF;

    typedef struct packed {
        logic                             library_ready;
        logic [ADDR_W-1:0]                map_base;
        logic [NUM_SIZES-1:0][OFS_W-1:0]  size_base;
    } cfg_t;

    typedef struct packed {
        logic       clear;
        logic       load_gbk;
        logic       load_utf;
        logic       start;
        logic       scan;
        logic       mul;
        logic       sum;
        logic       res_load;
        logic [1:0] res_sel;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic hit;
        logic miss;
        logic out_free;
    } sts_t;

endpackage

/* src/gl_req_if.sv */
// Request channel of the glyph locator: valid/ready plus item fields.
// Depends on gl_pkg.
interface gl_req_if;
    logic                          valid;
    logic                          ready;
    logic [gl_pkg::KIND_W-1:0]     kind;
    logic [gl_pkg::POS_W-1:0]      entry_pos;
    logic [gl_pkg::KEY_W-1:0]      key_bytes;
    logic [gl_pkg::KLEN_W-1:0]     key_len;
    logic [gl_pkg::GLYPH_W-1:0]    entry_glyph;
    logic [gl_pkg::SIZE_W-1:0]     px_size;

    modport source (output valid, kind, entry_pos, key_bytes, key_len, entry_glyph,
                    px_size, input ready);
    modport sink (input valid, kind, entry_pos, key_bytes, key_len, entry_glyph,
                  px_size, output ready);
endinterface

/* src/gl_rsp_if.sv */
// Response channel of the glyph locator: valid/ready plus result fields.
// Depends on gl_pkg.
interface gl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [gl_pkg::STATUS_W-1:0]   status;
    logic [gl_pkg::GLYPH_W-1:0]    glyph_index;
    logic [gl_pkg::ADDR_W-1:0]     glyph_address;

    modport source (output valid, status, glyph_index, glyph_address, input ready);
    modport sink (input valid, status, glyph_index, glyph_address, output ready);
endinterface

/* src/gl_cfg.sv */
// Configuration register file of the glyph locator.
// Depends on gl_pkg.
module gl_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [gl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output gl_pkg::cfg_t                   cfg
);
    import gl_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LIB_READY: cfg_next.library_ready = cfg_wdata[0];
                CFG_MAP_BASE:  cfg_next.map_base      = cfg_wdata[ADDR_W-1:0];
                CFG_BASE_12:   cfg_next.size_base[0]  = cfg_wdata[OFS_W-1:0];
                CFG_BASE_16:   cfg_next.size_base[1]  = cfg_wdata[OFS_W-1:0];
                CFG_BASE_20:   cfg_next.size_base[2]  = cfg_wdata[OFS_W-1:0];
                CFG_BASE_24:   cfg_next.size_base[3]  = cfg_wdata[OFS_W-1:0];
                CFG_BASE_32:   cfg_next.size_base[4]  = cfg_wdata[OFS_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/gl_ctrl.sv */
// Sequencer of the glyph locator: table clear, load, scan, address and reply.
// Depends on gl_pkg and glyph_locator_defines.svh.
`include "glyph_locator_defines.svh"

module gl_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic [gl_pkg::KIND_W-1:0]   req_kind,
    input  logic                        lib_ready,
    input  gl_pkg::sts_t                sts,
    output logic                        req_ready,
    output gl_pkg::cmd_t                cmd
);
    import gl_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_SUM   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] sel_reg;
    logic [1:0] sel_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    unique case (req_kind)
                        KIND_GBK_LOAD:
                        begin
                            cmd.load_gbk = 1'b1;
                            sel_next     = RES_LOADED;
                            state_next   = ST_OUT;
                        end
                        KIND_UTF_LOAD:
                        begin
                            cmd.load_utf = 1'b1;
                            sel_next     = RES_LOADED;
                            state_next   = ST_OUT;
                        end
                        default:
                        begin
                            if (lib_ready)
                            begin
                                cmd.start  = 1'b1;
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                sel_next   = RES_NOT_READY;
                                state_next = ST_OUT;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit)
                begin
                    state_next = ST_MUL;
                end
                else if (sts.miss)
                begin
                    sel_next   = RES_NOT_FOUND;
                    state_next = ST_OUT;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                sel_next   = RES_HIT;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                cmd.res_sel = sel_reg;
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            sel_reg   <= RES_LOADED;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    `GL_ASSERT_NEXT(a_lookup_scans,
        state_reg == ST_IDLE && req_valid && lib_ready &&
        (req_kind == KIND_GBK_FIND || req_kind == KIND_UTF_FIND),
        state_reg == ST_SCAN, "ready lookup did not start a scan")
    `GL_ASSERT_NEXT(a_hit_to_mul, state_reg == ST_SCAN && sts.hit,
        state_reg == ST_MUL, "scan hit did not enter address stage")
    `GL_ASSERT_NEXT(a_out_holds, state_reg == ST_OUT && !sts.out_free,
        state_reg == ST_OUT && $stable(sel_reg), "pending result dropped")
    `GL_ASSERT_SAME(a_no_accept_busy, state_reg != ST_IDLE, !req_ready,
        "transaction accepted while busy")

endmodule

/* src/gl_dp.sv */
// Datapath of the glyph locator: code tables, scan compare, address math
// and the result register. Depends on gl_pkg and glyph_locator_defines.svh.
`include "glyph_locator_defines.svh"

module gl_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gl_pkg::cmd_t                  cmd,
    input  gl_pkg::cfg_t                  cfg,
    input  logic [gl_pkg::POS_W-1:0]      req_entry_pos,
    input  logic [gl_pkg::KEY_W-1:0]      req_key_bytes,
    input  logic [gl_pkg::KLEN_W-1:0]     req_key_len,
    input  logic [gl_pkg::GLYPH_W-1:0]    req_entry_glyph,
    input  logic [gl_pkg::SIZE_W-1:0]     req_px_size,
    input  logic [gl_pkg::KIND_W-1:0]     req_kind,
    input  logic                          rsp_ready,
    output logic                          rsp_valid,
    output logic [gl_pkg::STATUS_W-1:0]   rsp_status,
    output logic [gl_pkg::GLYPH_W-1:0]    rsp_glyph_index,
    output logic [gl_pkg::ADDR_W-1:0]     rsp_glyph_address,
    output gl_pkg::sts_t                  sts
);
    import gl_pkg::*;

    localparam int GBK_W  = 16 + GLYPH_W;
    localparam int UTF_W  = KEY_W + KLEN_W + GLYPH_W;
    localparam int BPG_W  = 8;
    localparam int PROD_W = GLYPH_W + BPG_W;

    localparam logic [7:0] LEAD_M1 = 8'h80;
    localparam logic [7:0] LEAD_M2 = 8'hE0;
    localparam logic [7:0] LEAD_P2 = 8'hC0;
    localparam logic [7:0] LEAD_M3 = 8'hF0;
    localparam logic [7:0] LEAD_P3 = 8'hE0;
    localparam logic [7:0] LEAD_M4 = 8'hF8;
    localparam logic [7:0] LEAD_P4 = 8'hF0;

    localparam logic [SIZE_W-1:0] SIZE_12 = 8'd12;
    localparam logic [SIZE_W-1:0] SIZE_16 = 8'd16;
    localparam logic [SIZE_W-1:0] SIZE_20 = 8'd20;
    localparam logic [SIZE_W-1:0] SIZE_24 = 8'd24;
    localparam logic [SIZE_W-1:0] SIZE_32 = 8'd32;
    localparam logic [BPG_W-1:0]  BPG_12  = 8'd24;
    localparam logic [BPG_W-1:0]  BPG_16  = 8'd32;
    localparam logic [BPG_W-1:0]  BPG_20  = 8'd60;
    localparam logic [BPG_W-1:0]  BPG_24  = 8'd72;
    localparam logic [BPG_W-1:0]  BPG_32  = 8'd128;
    localparam logic [ADDR_W-1:0] GLYPH_HDR = 32'd18;

    function automatic logic [KLEN_W-1:0] lead_len(input logic [7:0] lead);
        logic [KLEN_W-1:0] n;
        priority if ((lead & LEAD_M1) == 8'h00) n = 3'd1;
        else if ((lead & LEAD_M2) == LEAD_P2)   n = 3'd2;
        else if ((lead & LEAD_M3) == LEAD_P3)   n = 3'd3;
        else if ((lead & LEAD_M4) == LEAD_P4)   n = 3'd4;
        else                                    n = 3'd1;
        return n;
    endfunction

    function automatic logic [KEY_W-1:0] len_mask(input logic [KLEN_W-1:0] n);
        logic [KEY_W-1:0] m;
        unique case (n)
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // tables
    logic [GBK_W-1:0] gbk_mem [TABLE_DEPTH];
    logic [UTF_W-1:0] utf_mem [TABLE_DEPTH];
    logic [GBK_W-1:0] gbk_q_reg;
    logic [UTF_W-1:0] utf_q_reg;

    logic [31:0]       pos_ext;
    logic              pos_ok;
    logic [TBL_AW-1:0] wr_addr;
    logic              gbk_we;
    logic              utf_we;
    logic [GBK_W-1:0]  gbk_wdata;
    logic [UTF_W-1:0]  utf_wdata;

    logic [TBL_AW-1:0] clr_cnt_reg;
    logic [TBL_CW-1:0] scan_cnt_reg;
    logic              issue;
    logic [TBL_AW-1:0] rd_addr;
    logic              q_vld_reg;
    logic              q_last_reg;

    // latched lookup item
    logic              is_utf_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [KLEN_W-1:0] ulen_reg;
    logic [KEY_W-1:0]  umask_reg;
    logic [SIZE_W-1:0] size_reg;

    logic [15:0]        gbk_key;
    logic [GLYPH_W-1:0] gbk_glyph;
    logic [KEY_W-1:0]   utf_key;
    logic [KLEN_W-1:0]  utf_len;
    logic [GLYPH_W-1:0] utf_glyph;
    logic               gbk_end;
    logic               match;
    logic               stop_miss;
    logic               hit;
    logic               miss;

    logic [GLYPH_W-1:0] g_reg;
    logic [OFS_W-1:0]   sel_base;
    logic [BPG_W-1:0]   sel_bpg;
    logic [PROD_W-1:0]  prod_reg;
    logic [ADDR_W-1:0]  base_sum_reg;
    logic               bad_reg;
    logic [ADDR_W-1:0]  addr_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [GLYPH_W-1:0]  out_glyph_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic                out_free;

    assign pos_ext = 32'(req_entry_pos);
    assign pos_ok  = pos_ext < 32'(TABLE_DEPTH);

    always_comb
    begin
        if (cmd.clear)
        begin
            wr_addr   = clr_cnt_reg;
            gbk_we    = 1'b1;
            utf_we    = 1'b1;
            gbk_wdata = {GBK_END, {GLYPH_W{1'b0}}};
            utf_wdata = '0;
        end
        else
        begin
            wr_addr   = pos_ext[TBL_AW-1:0];
            gbk_we    = cmd.load_gbk && pos_ok;
            utf_we    = cmd.load_utf && pos_ok;
            gbk_wdata = {req_key_bytes[15:0], req_entry_glyph};
            utf_wdata = {req_key_bytes, req_key_len, req_entry_glyph};
        end
    end

    assign issue   = cmd.scan && (scan_cnt_reg != TBL_CW'(TABLE_DEPTH));
    assign rd_addr = scan_cnt_reg[TBL_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (gbk_we)
        begin
            gbk_mem[wr_addr] <= gbk_wdata;
        end
        gbk_q_reg <= gbk_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (utf_we)
        begin
            utf_mem[wr_addr] <= utf_wdata;
        end
        utf_q_reg <= utf_mem[rd_addr];
    end

    assign gbk_key   = gbk_q_reg[GBK_W-1:GLYPH_W];
    assign gbk_glyph = gbk_q_reg[GLYPH_W-1:0];
    assign utf_key   = utf_q_reg[UTF_W-1:KLEN_W+GLYPH_W];
    assign utf_len   = utf_q_reg[KLEN_W+GLYPH_W-1:GLYPH_W];
    assign utf_glyph = utf_q_reg[GLYPH_W-1:0];

    assign gbk_end = gbk_key == GBK_END;

    always_comb
    begin
        if (is_utf_reg)
        begin
            match     = (utf_len == ulen_reg) && (((utf_key ^ key_reg) & umask_reg) == '0);
            stop_miss = 1'b0;
        end
        else
        begin
            match     = !gbk_end && (gbk_key == key_reg[15:0]);
            stop_miss = gbk_end;
        end
    end

    assign hit  = cmd.scan && q_vld_reg && match;
    assign miss = cmd.scan && q_vld_reg && !match && (stop_miss || q_last_reg);

    always_comb
    begin
        unique case (size_reg)
            SIZE_12: begin sel_base = cfg.size_base[0]; sel_bpg = BPG_12; end
            SIZE_16: begin sel_base = cfg.size_base[1]; sel_bpg = BPG_16; end
            SIZE_20: begin sel_base = cfg.size_base[2]; sel_bpg = BPG_20; end
            SIZE_24: begin sel_base = cfg.size_base[3]; sel_bpg = BPG_24; end
            SIZE_32: begin sel_base = cfg.size_base[4]; sel_bpg = BPG_32; end
            default: begin sel_base = '0;               sel_bpg = '0;     end
        endcase
    end

    // scan and clear control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            scan_cnt_reg <= '0;
            q_vld_reg    <= 1'b0;
            q_last_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.start)
            begin
                scan_cnt_reg <= '0;
                q_vld_reg    <= 1'b0;
                q_last_reg   <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                q_vld_reg  <= issue;
                q_last_reg <= issue && (scan_cnt_reg == TBL_CW'(TABLE_DEPTH - 1));
            end
        end
    end

    // item latch and address math
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            is_utf_reg <= req_kind == KIND_UTF_FIND;
            key_reg    <= req_key_bytes;
            ulen_reg   <= lead_len(req_key_bytes[7:0]);
            umask_reg  <= len_mask(lead_len(req_key_bytes[7:0]));
            size_reg   <= req_px_size;
        end
        if (hit)
        begin
            g_reg <= is_utf_reg ? utf_glyph : gbk_glyph;
        end
        if (cmd.mul)
        begin
            prod_reg     <= PROD_W'(g_reg) * PROD_W'(sel_bpg);
            base_sum_reg <= cfg.map_base + ADDR_W'(sel_base) + GLYPH_HDR;
            bad_reg      <= sel_base == '0;
        end
        if (cmd.sum)
        begin
            addr_reg <= base_sum_reg + ADDR_W'(prod_reg);
        end
    end

    // result register
    assign out_free = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            unique case (cmd.res_sel)
                RES_LOADED:
                begin
                    out_status_reg <= STS_OK;
                    out_glyph_reg  <= '0;
                    out_addr_reg   <= '0;
                end
                RES_NOT_READY:
                begin
                    out_status_reg <= STS_NOT_READY;
                    out_glyph_reg  <= '0;
                    out_addr_reg   <= '0;
                end
                RES_NOT_FOUND:
                begin
                    out_status_reg <= STS_NOT_FOUND;
                    out_glyph_reg  <= '0;
                    out_addr_reg   <= '0;
                end
                default:
                begin
                    out_status_reg <= bad_reg ? STS_BAD_SIZE : STS_OK;
                    out_glyph_reg  <= g_reg;
                    out_addr_reg   <= bad_reg ? '0 : addr_reg;
                end
            endcase
        end
    end

    assign rsp_valid         = out_valid_reg;
    assign rsp_status        = out_status_reg;
    assign rsp_glyph_index   = out_glyph_reg;
    assign rsp_glyph_address = out_addr_reg;

    assign sts.clear_last = cmd.clear && (clr_cnt_reg == TBL_AW'(TABLE_DEPTH - 1));
    assign sts.hit        = hit;
    assign sts.miss       = miss;
    assign sts.out_free   = out_free;

    `GL_ASSERT_SAME(a_hit_miss_excl, hit || miss, $onehot({hit, miss}),
        "scan reported hit and miss together")
    `GL_ASSERT_SAME(a_scan_bound, 1'b1, scan_cnt_reg <= TBL_CW'(TABLE_DEPTH),
        "scan counter ran past table end")
    `GL_ASSERT_SAME(a_load_when_free, cmd.res_load, out_free,
        "result overwritten before transaction completed")

endmodule

/* src/glyph_locator.sv */
// Glyph locator. After reset a clear pass over all TABLE_DEPTH (8192) entries fills the
// tables with end markers and zero lengths; no transaction is accepted until it ends.
// Loads and not-ready lookups go from accept straight to the output stage, which loads
// the result register once it is free. A ready lookup scans the table one entry per cycle
// on the read port until a hit or a miss, then forms the address in a multiply and a sum step.
// One item at a time; the next is accepted once the previous result is registered.
module glyph_locator (
    input  logic                           clk,
    input  logic                           rst_n,
    gl_req_if.sink                         req,
    gl_rsp_if.source                       rsp,
    input  logic                           cfg_we,
    input  logic [gl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import gl_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;
    logic req_ready;

    gl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    gl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind),
        .lib_ready (cfg.library_ready),
        .sts       (sts),
        .req_ready (req_ready),
        .cmd       (cmd)
    );

    gl_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg               (cfg),
        .req_entry_pos     (req.entry_pos),
        .req_key_bytes     (req.key_bytes),
        .req_key_len       (req.key_len),
        .req_entry_glyph   (req.entry_glyph),
        .req_px_size       (req.px_size),
        .req_kind          (req.kind),
        .rsp_ready         (rsp.ready),
        .rsp_valid         (rsp.valid),
        .rsp_status        (rsp.status),
        .rsp_glyph_index   (rsp.glyph_index),
        .rsp_glyph_address (rsp.glyph_address),
        .sts               (sts)
    );

    assign req.ready = req_ready;

endmodule

/* tb/glyph_locator_tb.sv */
// Self-checking testbench for glyph_locator: GBK and UTF-8 table loads and lookups,
// directed then random, each result checked against a behavioral table model.
// Depends on gl_pkg, gl_req_if, gl_rsp_if and glyph_locator.
module glyph_locator_tb;
    import gl_pkg::*;

    localparam int IDLE_LIMIT  = 40000;
    localparam int MAX_WAIT    = 17;
    localparam int TAIL_CYCLES = 64;
    localparam int RANDOM_PER_PHASE = 15;

    typedef struct packed {
        bit [KIND_W-1:0]  kind;
        bit [POS_W-1:0]   entry_pos;
        bit [KEY_W-1:0]   key_bytes;
        bit [KLEN_W-1:0]  key_len;
        bit [GLYPH_W-1:0] entry_glyph;
        bit [SIZE_W-1:0]  px_size;
    } glyph_req_t;

    typedef struct packed {
        bit [STATUS_W-1:0] status;
        bit [GLYPH_W-1:0]  glyph_index;
        bit [ADDR_W-1:0]   glyph_address;
    } glyph_rsp_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    gl_req_if req_ch();
    gl_rsp_if rsp_ch();

    glyph_locator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // register mirror
    bit              lib_ready;
    bit [ADDR_W-1:0] map_base_q;
    bit [OFS_W-1:0]  size_base [NUM_SIZES];

    // table mirror
    bit [15:0]         gbk_key_tbl   [TABLE_DEPTH];
    bit [GLYPH_W-1:0]  gbk_glyph_tbl [TABLE_DEPTH];
    bit [KEY_W-1:0]    utf_key_tbl   [TABLE_DEPTH];
    bit [KLEN_W-1:0]   utf_len_tbl   [TABLE_DEPTH];
    bit [GLYPH_W-1:0]  utf_glyph_tbl [TABLE_DEPTH];

    glyph_req_t request_queue [$];
    glyph_rsp_t glyph_results_due [$];
    glyph_req_t in_flight;
    glyph_rsp_t predicted;
    glyph_rsp_t want;

    // what the random generator knows has been loaded
    bit [15:0]      gbk_known [$];
    bit [KEY_W-1:0] utf_known_key [$];
    int             utf_known_len [$];
    int gbk_next;
    int utf_next;

    bit back_to_back;
    int send_gap;
    int take_gap;
    int idle_cycles;
    int mismatch_count;
    int loads_done;
    int lookup_outcomes [4];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic glyph_rsp_t locate_glyph(input glyph_req_t r);
        glyph_rsp_t       res;
        bit               hit;
        bit [GLYPH_W-1:0] g;
        int               len;
        int               i;
        bit [31:0]        mask;
        bit [OFS_W-1:0]   base;
        int               bpg;
        res = '0;
        hit = 1'b0;
        g = '0;
        if (r.kind == KIND_GBK_LOAD)
        begin
            gbk_key_tbl[r.entry_pos]   = r.key_bytes[15:0];
            gbk_glyph_tbl[r.entry_pos] = r.entry_glyph;
        end
        else if (r.kind == KIND_UTF_LOAD)
        begin
            utf_key_tbl[r.entry_pos]   = r.key_bytes;
            utf_len_tbl[r.entry_pos]   = r.key_len;
            utf_glyph_tbl[r.entry_pos] = r.entry_glyph;
        end
        else if (!lib_ready)
            res.status = STS_NOT_READY;
        else
        begin
            i = 0;
            if (r.kind == KIND_GBK_FIND)
            begin
                while (i < TABLE_DEPTH && !hit && gbk_key_tbl[i] != GBK_END)
                begin
                    if (gbk_key_tbl[i] == r.key_bytes[15:0])
                    begin
                        hit = 1'b1;
                        g = gbk_glyph_tbl[i];
                    end
                    i++;
                end
            end
            else
            begin
                casez (r.key_bytes[7:0])
                    8'b0???????: len = 1;
                    8'b110?????: len = 2;
                    8'b1110????: len = 3;
                    8'b11110???: len = 4;
                    default:     len = 1;
                endcase
                mask = (len == 4) ? 32'hFFFF_FFFF : ((32'h1 << (8 * len)) - 32'h1);
                while (i < TABLE_DEPTH && !hit)
                begin
                    if (utf_len_tbl[i] == len && (utf_key_tbl[i] & mask) == (r.key_bytes & mask))
                    begin
                        hit = 1'b1;
                        g = utf_glyph_tbl[i];
                    end
                    i++;
                end
            end
            if (!hit)
                res.status = STS_NOT_FOUND;
            else
            begin
                case (r.px_size)
                    8'd12:   begin base = size_base[0]; bpg = 24;  end
                    8'd16:   begin base = size_base[1]; bpg = 32;  end
                    8'd20:   begin base = size_base[2]; bpg = 60;  end
                    8'd24:   begin base = size_base[3]; bpg = 72;  end
                    8'd32:   begin base = size_base[4]; bpg = 128; end
                    default: begin base = '0;           bpg = 0;   end
                endcase
                res.glyph_index = g;
                if (base == '0)
                    res.status = STS_BAD_SIZE;
                else
                begin
                    res.status = STS_OK;
                    res.glyph_address = map_base_q + 32'(base) + 32'd18 + 32'(g) * 32'(bpg);
                end
            end
        end
        return res;
    endfunction

    function automatic int draw_wait();
        return back_to_back ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp);
        $display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, got, exp);
        mismatch_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predicted = locate_glyph(in_flight);
                glyph_results_due.push_back(predicted);
                if (in_flight.kind == KIND_GBK_LOAD || in_flight.kind == KIND_UTF_LOAD)
                    loads_done++;
                else
                    lookup_outcomes[predicted.status]++;
                send_gap = draw_wait();
            end
            if (!(req_ch.valid && !req_ch.ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (request_queue.size() != 0)
                begin
                    in_flight = request_queue.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.kind        <= in_flight.kind;
                    req_ch.entry_pos   <= in_flight.entry_pos;
                    req_ch.key_bytes   <= in_flight.key_bytes;
                    req_ch.key_len     <= in_flight.key_len;
                    req_ch.entry_glyph <= in_flight.entry_glyph;
                    req_ch.px_size     <= in_flight.px_size;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            take_gap = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (glyph_results_due.size() == 0)
                    report_mismatch("unrequested transaction, status", rsp_ch.status, 'x);
                else
                begin
                    want = glyph_results_due.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", rsp_ch.status, want.status);
                    if (rsp_ch.glyph_index !== want.glyph_index)
                        report_mismatch("glyph_index", rsp_ch.glyph_index, want.glyph_index);
                    if (rsp_ch.glyph_address !== want.glyph_address)
                        report_mismatch("glyph_address", rsp_ch.glyph_address,
                                        want.glyph_address);
                end
                take_gap = draw_wait();
            end
            if (take_gap > 0)
            begin
                take_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("glyph_locator verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_LIB_READY)
            lib_ready = data[0];
        else if (idx == CFG_MAP_BASE)
            map_base_q = data;
        else
            size_base[idx - CFG_BASE_12] = data[OFS_W-1:0];
    endtask

    task automatic configure(input bit ready, input bit [31:0] map,
                             input bit [31:0] b12, input bit [31:0] b16,
                             input bit [31:0] b20, input bit [31:0] b24,
                             input bit [31:0] b32);
        bit [31:0] bases [NUM_SIZES];
        int k;
        bases = '{b12, b16, b20, b24, b32};
        write_reg(CFG_LIB_READY, 32'(ready));
        write_reg(CFG_MAP_BASE, map);
        for (k = 0; k < NUM_SIZES; k++)
            write_reg(CFG_BASE_12 + CFG_IDX_W'(k), bases[k]);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (request_queue.size() != 0 || req_ch.valid || glyph_results_due.size() != 0);
    endtask

    // fields that the kind does not use are left random
    function automatic glyph_req_t scrambled(input bit [KIND_W-1:0] kind);
        glyph_req_t r;
        r.kind        = kind;
        r.entry_pos   = POS_W'($urandom);
        r.key_bytes   = $urandom;
        r.key_len     = KLEN_W'($urandom);
        r.entry_glyph = GLYPH_W'($urandom);
        r.px_size     = SIZE_W'($urandom);
        return r;
    endfunction

    task automatic gbk_load(input bit [POS_W-1:0] pos, input bit [15:0] code,
                            input bit [GLYPH_W-1:0] glyph);
        glyph_req_t r;
        r = scrambled(KIND_GBK_LOAD);
        r.entry_pos = pos;
        r.key_bytes[15:0] = code;
        r.entry_glyph = glyph;
        request_queue.push_back(r);
        if (code != GBK_END)
            gbk_known.push_back(code);
    endtask

    task automatic utf_load(input bit [POS_W-1:0] pos, input bit [KEY_W-1:0] key,
                            input bit [KLEN_W-1:0] len, input bit [GLYPH_W-1:0] glyph);
        glyph_req_t r;
        r = scrambled(KIND_UTF_LOAD);
        r.entry_pos = pos;
        r.key_bytes = key;
        r.key_len = len;
        r.entry_glyph = glyph;
        request_queue.push_back(r);
    endtask

    task automatic gbk_find(input bit [15:0] code, input bit [SIZE_W-1:0] size);
        glyph_req_t r;
        r = scrambled(KIND_GBK_FIND);
        r.key_bytes[15:0] = code;
        r.px_size = size;
        request_queue.push_back(r);
    endtask

    task automatic utf_find(input bit [KEY_W-1:0] key, input bit [SIZE_W-1:0] size);
        glyph_req_t r;
        r = scrambled(KIND_UTF_FIND);
        r.key_bytes = key;
        r.px_size = size;
        request_queue.push_back(r);
    endtask

    function automatic bit [SIZE_W-1:0] font_px();
        case ($urandom_range(0, 5))
            0:       return 8'd12;
            1:       return 8'd16;
            2:       return 8'd20;
            3:       return 8'd24;
            4:       return 8'd32;
            default: return SIZE_W'($urandom);
        endcase
    endfunction

    function automatic bit [31:0] pick_base();
        return ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom_range(1, 24'hFF_FFFF));
    endfunction

    // random UTF-8 sequence; bytes above the length stay random
    function automatic bit [KEY_W-1:0] utf_sequence(output int len);
        bit [KEY_W-1:0] key;
        key = $urandom;
        len = $urandom_range(1, 4);
        case (len)
            1: key[7]   = 1'b0;
            2: key[7:5] = 3'b110;
            3: key[7:4] = 4'b1110;
            default: key[7:3] = 5'b11110;
        endcase
        if ($urandom_range(0, 9) == 0)
        begin
            len = 1;
            key[7:6] = 2'b10;
            if ($urandom_range(0, 1) == 1)
                key[7:3] = 5'b11111;
        end
        return key;
    endfunction

    task automatic add_random_item();
        int             pick;
        int             len;
        int             slot;
        bit [KEY_W-1:0] key;
        bit [31:0]      mask;
        bit [15:0]      code;
        bit [POS_W-1:0] pos;
        pick = $urandom_range(0, 99);
        if (pick < 28)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                code = ($urandom_range(0, 9) == 0) ? GBK_END : 16'($urandom_range(0, 16'hFFFE));
                gbk_load(POS_W'($urandom_range(0, TABLE_DEPTH - 1)), code, GLYPH_W'($urandom));
            end
            else
            begin
                gbk_load(POS_W'(gbk_next), 16'($urandom_range(0, 16'hFFFE)), GLYPH_W'($urandom));
                gbk_next++;
            end
        end
        else if (pick < 52)
        begin
            key = utf_sequence(len);
            if ($urandom_range(0, 5) == 0)
                pos = POS_W'($urandom_range(0, TABLE_DEPTH - 1));
            else
            begin
                pos = POS_W'(utf_next);
                utf_next++;
            end
            if ($urandom_range(0, 9) == 0)
                utf_load(pos, key, KLEN_W'($urandom_range(0, 7)), GLYPH_W'($urandom));
            else
            begin
                utf_load(pos, key, KLEN_W'(len), GLYPH_W'($urandom));
                utf_known_key.push_back(key);
                utf_known_len.push_back(len);
            end
        end
        else if (pick < 78)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7 && gbk_known.size() != 0)
                code = gbk_known[$urandom_range(0, gbk_known.size() - 1)];
            else if (pick < 9)
                code = 16'($urandom);
            else
                code = GBK_END;
            gbk_find(code, font_px());
        end
        else
        begin
            if ($urandom_range(0, 9) < 8 && utf_known_key.size() != 0)
            begin
                slot = $urandom_range(0, utf_known_key.size() - 1);
                len = utf_known_len[slot];
                mask = (len == 4) ? 32'hFFFF_FFFF : ((32'h1 << (8 * len)) - 32'h1);
                key = (utf_known_key[slot] & mask) | ($urandom & ~mask);
            end
            else
                key = utf_sequence(len);
            utf_find(key, font_px());
        end
    endtask

    initial
    begin : stimulus
        int i;
        int phase;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            gbk_key_tbl[i]   = GBK_END;
            gbk_glyph_tbl[i] = '0;
            utf_key_tbl[i]   = '0;
            utf_len_tbl[i]   = '0;
            utf_glyph_tbl[i] = '0;
        end
        lib_ready = 1'b0;
        map_base_q = '0;
        for (i = 0; i < NUM_SIZES; i++)
            size_base[i] = '0;
        back_to_back = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_LIB_READY;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_GBK_LOAD;
        req_ch.entry_pos = '0;
        req_ch.key_bytes = '0;
        req_ch.key_len = '0;
        req_ch.entry_glyph = '0;
        req_ch.px_size = '0;
        rsp_ch.ready = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // library absent: loads still land, lookups refused
        gbk_load(0, 16'h8140, 13'd0);
        utf_load(0, 32'h0000_0041, 3'd1, 13'h1FFF);
        gbk_find(16'h8140, 8'd12);
        wait_idle();

        // address wraps past 2^32; 20 px unavailable
        configure(1'b1, 32'hFFFF_FFF0, 32'h00FF_FFFF, 32'd1, 32'd0, 32'h00AB_CDEF,
                  32'h0012_3456);
        gbk_load(1, 16'h0000, 13'h1FFF);
        gbk_load(2, 16'hFEFE, 13'd1);
        gbk_load(3, GBK_END, 13'd7);
        gbk_load(4, 16'h1234, 13'd5);
        gbk_find(16'h8140, 8'd12);
        gbk_find(16'h0000, 8'd32);
        gbk_find(16'hFEFE, 8'd20);
        gbk_find(16'h1234, 8'd24);
        gbk_find(GBK_END, 8'd16);
        gbk_load(3, 16'h4321, 13'd100);
        gbk_find(16'h1234, 8'd24);
        utf_load(1, 32'h0000_A9C2, 3'd2, 13'd2);
        utf_load(2, 32'h00AD_B8E4, 3'd3, 13'd3);
        utf_load(3, 32'h8098_9FF0, 3'd4, 13'd4);
        utf_load(4, 32'h0000_00FF, 3'd1, 13'd6);
        utf_load(5, 32'h0000_0042, 3'd0, 13'd8);
        utf_find(32'hDEAD_BE41, 8'd16);
        utf_find(32'h1234_A9C2, 8'd20);
        utf_find(32'hFFAD_B8E4, 8'd24);
        utf_find(32'h8098_9FF0, 8'd32);
        utf_find(32'hABCD_EFFF, 8'd12);
        utf_find(32'h0000_0042, 8'd12);
        wait_idle();

        gbk_next = 5;
        utf_next = 6;
        for (phase = 0; phase < 5; phase++)
        begin
            back_to_back = (phase == 0);
            case (phase)
                0: configure(1'b1, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF,
                             32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF);
                1: configure(1'b1, $urandom, pick_base(), pick_base(), pick_base(),
                             pick_base(), pick_base());
                2: configure(1'b0, 32'd0, pick_base(), pick_base(), pick_base(),
                             pick_base(), pick_base());
                3: configure(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom);
                default: configure(1'b1, 32'd0, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1);
            endcase
            repeat (RANDOM_PER_PHASE) add_random_item();
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d table loads and %0d lookups across 7 register settings",
                 loads_done, lookup_outcomes[0] + lookup_outcomes[1] + lookup_outcomes[2]
                 + lookup_outcomes[3]);
        $display("lookups: %0d hits, %0d not ready, %0d not found, %0d bad size",
                 lookup_outcomes[STS_OK], lookup_outcomes[STS_NOT_READY],
                 lookup_outcomes[STS_NOT_FOUND], lookup_outcomes[STS_BAD_SIZE]);
        if (mismatch_count == 0)
            $display("glyph_locator verification clean");
        else
            $display("glyph_locator verification failed");
        $finish;
    end

endmodule
